[design/sbsi_pkg.sv]
// ----------------------------------------------------------------------------
// sbsi_pkg - shared types and constants
// Field widths, beat layouts and per-axis setup records for the segment/box
// slab intersection pipeline.
// ----------------------------------------------------------------------------
package sbsi_pkg;

    localparam int COORD_W = 31;            // signed Q15.16 coordinate
    localparam int SIZE_W  = 30;            // unsigned Q14.16 box size
    localparam int DW      = 32;            // slab distances and divisor width
    localparam int IN_W    = 248;           // 246 bits of fields, byte padded
    localparam int OUT_W   = 72;            // 67 bits of fields, byte padded

    localparam logic signed [1:0] NRM_ZERO = 2'sb00;
    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;

    // per-axis setup after the first stage
    typedef struct packed {
        logic          rej;       // segment wholly outside the slab
        logic          near_div;  // near t needs a division, else 0
        logic          far_div;   // far t needs a division, else 1
        logic          dec;       // coordinate decreasing or constant
        logic [DW-1:0] near_num;
        logic [DW-1:0] far_num;
        logic [DW-1:0] den;
    } axis_t;

    // data riding alongside the dividers
    typedef struct packed {
        logic                      rej_x;
        logic                      near_div_x;
        logic                      far_div_x;
        logic                      dec_x;
        logic                      rej_y;
        logic                      near_div_y;
        logic                      far_div_y;
        logic                      dec_y;
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [DW-1:0]      dx;
        logic signed [DW-1:0]      dy;
    } side_t;

endpackage

[design/segment_box_slab_intersect_unit.sv]
// ----------------------------------------------------------------------------
// segment_box_slab_intersect_unit - 2D segment vs. axis-aligned box test
// Slab method over t in [0,1]: entry flag, entry point and entry face normal.
// Throughput: one beat per cycle unless the output stalls; the FRAC_BITS+1 stage dividers set depth.
// The whole pipe advances when the output register is empty or taken.
// Reset: aresetn (sync, active low) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module segment_box_slab_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // from_x, from_y, to_x, to_y, rect_x, rect_y (31b each), rect_w, rect_h
    // (30b each), low bits first, 2 zero pad bits
    input  logic [sbsi_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // hit (1b), hit_x (31b), hit_y (31b), normal_x (2b), normal_y (2b),
    // low bits first, 5 zero pad bits
    output logic [sbsi_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready
);
    localparam int NST = FRAC_BITS + 1;     // divider depth
    localparam int CW  = sbsi_pkg::COORD_W;
    localparam int DW  = sbsi_pkg::DW;
    localparam int PW  = DW + FRAC_BITS + 2; // product width
    localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // global advance: output slot free or being taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: unpack, slab setup ----------------
    function automatic sbsi_pkg::axis_t axis_prep(
        input logic signed [CW-1:0] f,
        input logic signed [CW-1:0] t,
        input logic signed [CW-1:0] lo,
        input logic signed [DW-1:0] hi
    );
        logic signed [DW:0] fe, te, le, he;
        sbsi_pkg::axis_t r;
        fe = (DW+1)'(f);
        te = (DW+1)'(t);
        le = (DW+1)'(lo);
        he = (DW+1)'(hi);
        r  = '0;
        if (fe < te) begin
            r.rej      = (fe > he) || (te < le);
            r.near_div = fe < le;
            r.far_div  = te > he;
            r.near_num = DW'(le - fe);
            r.far_num  = DW'(he - fe);
            r.den      = DW'(te - fe);
            r.dec      = 1'b0;
        end else begin
            r.rej      = (te > he) || (fe < le);
            r.near_div = fe > he;
            r.far_div  = te < le;
            r.near_num = DW'(fe - he);
            r.far_num  = DW'(fe - le);
            r.den      = DW'(fe - te);
            r.dec      = 1'b1;
        end
        return r;
    endfunction

    logic signed [CW-1:0] in_from_x, in_from_y, in_to_x, in_to_y, in_rx, in_ry;
    logic [sbsi_pkg::SIZE_W-1:0] in_rw, in_rh;
    logic signed [DW-1:0] in_hx, in_hy;
    sbsi_pkg::axis_t ax_next, ay_next, ax_reg, ay_reg;
    sbsi_pkg::side_t side_next, side1_reg;
    logic v1_reg;

    assign in_from_x = s_tdata[30:0];
    assign in_from_y = s_tdata[61:31];
    assign in_to_x   = s_tdata[92:62];
    assign in_to_y   = s_tdata[123:93];
    assign in_rx     = s_tdata[154:124];
    assign in_ry     = s_tdata[185:155];
    assign in_rw     = s_tdata[215:186];
    assign in_rh     = s_tdata[245:216];

    // box max, exact in one extra bit
    assign in_hx = DW'(in_rx) + DW'(in_rw);
    assign in_hy = DW'(in_ry) + DW'(in_rh);

    always_comb begin
        ax_next = axis_prep(in_from_x, in_to_x, in_rx, in_hx);
        ay_next = axis_prep(in_from_y, in_to_y, in_ry, in_hy);
        side_next.rej_x      = ax_next.rej;
        side_next.near_div_x = ax_next.near_div;
        side_next.far_div_x  = ax_next.far_div;
        side_next.dec_x      = ax_next.dec;
        side_next.rej_y      = ay_next.rej;
        side_next.near_div_y = ay_next.near_div;
        side_next.far_div_y  = ay_next.far_div;
        side_next.dec_y      = ay_next.dec;
        side_next.from_x     = in_from_x;
        side_next.from_y     = in_from_y;
        side_next.dx         = DW'(in_to_x) - DW'(in_from_x);
        side_next.dy         = DW'(in_to_y) - DW'(in_from_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            side1_reg <= side_next;
        end
    end

    // ---------------- dividers: near/far t per axis ----------------
    logic [FRAC_BITS:0] q_nx, q_fx, q_ny, q_fy;

    sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_nx (
        .aclk(aclk), .en(en), .num(ax_reg.near_num), .den(ax_reg.den), .q(q_nx));
    sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_fx (
        .aclk(aclk), .en(en), .num(ax_reg.far_num), .den(ax_reg.den), .q(q_fx));
    sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_ny (
        .aclk(aclk), .en(en), .num(ay_reg.near_num), .den(ay_reg.den), .q(q_ny));
    sbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_fy (
        .aclk(aclk), .en(en), .num(ay_reg.far_num), .den(ay_reg.den), .q(q_fy));

    // sideband delay line matching divider depth
    sbsi_pkg::side_t side_d_reg[NST];
    logic            vd_reg    [NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) vd_reg[k] <= 1'b0;
        end else if (en) begin
            vd_reg[0] <= v1_reg;
            for (int k = 1; k < NST; k++) vd_reg[k] <= vd_reg[k-1];
        end
        if (en) begin
            side_d_reg[0] <= side1_reg;
            for (int k = 1; k < NST; k++) side_d_reg[k] <= side_d_reg[k-1];
        end
    end

    // ---------------- stage A: interval narrowing ----------------
    sbsi_pkg::side_t sd;
    logic [FRAC_BITS:0] tn_x, tf_x, tn_y, tf_y, tmin_x, tmax_x, tmin_next;
    logic hit_next, ent_x, ent_y;
    logic signed [1:0] nx_next, ny_next;

    assign sd = side_d_reg[NST-1];

    always_comb begin
        tn_x = sd.near_div_x ? q_nx : '0;
        tf_x = sd.far_div_x  ? q_fx : T_ONE;
        tn_y = sd.near_div_y ? q_ny : '0;
        tf_y = sd.far_div_y  ? q_fy : T_ONE;
        // x axis
        ent_x  = tn_x != '0;
        tmin_x = tn_x;
        tmax_x = tf_x;
        // y axis: takes the entry only when strictly later
        ent_y     = tn_y > tmin_x;
        tmin_next = ent_y ? tn_y : tmin_x;
        hit_next  = !sd.rej_x && (tmin_x <= tmax_x) && !sd.rej_y
                    && (tmin_next <= ((tf_y < tmax_x) ? tf_y : tmax_x));
        nx_next = sbsi_pkg::NRM_ZERO;
        ny_next = sbsi_pkg::NRM_ZERO;
        if (ent_y) begin
            ny_next = sd.dec_y ? sbsi_pkg::NRM_POS : sbsi_pkg::NRM_NEG;
        end else if (ent_x) begin
            nx_next = sd.dec_x ? sbsi_pkg::NRM_POS : sbsi_pkg::NRM_NEG;
        end
    end

    logic                 va_reg, hita_reg;
    logic [FRAC_BITS:0]   tmin_reg;
    logic signed [1:0]    nxa_reg, nya_reg;
    logic signed [CW-1:0] fxa_reg, fya_reg;
    logic signed [DW-1:0] dxa_reg, dya_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= vd_reg[NST-1];
        end
        if (en) begin
            hita_reg <= hit_next;
            tmin_reg <= tmin_next;
            nxa_reg  <= nx_next;
            nya_reg  <= ny_next;
            fxa_reg  <= sd.from_x;
            fya_reg  <= sd.from_y;
            dxa_reg  <= sd.dx;
            dya_reg  <= sd.dy;
        end
    end

    // ---------------- stage B: direction times t ----------------
    logic signed [FRAC_BITS+1:0] tmin_s;
    logic signed [PW-1:0]        px_next, py_next, px_reg, py_reg;
    logic                        vb_reg, hitb_reg;
    logic signed [1:0]           nxb_reg, nyb_reg;
    logic signed [CW-1:0]        fxb_reg, fyb_reg;

    assign tmin_s  = signed'({1'b0, tmin_reg});
    assign px_next = PW'(dxa_reg) * PW'(tmin_s);
    assign py_next = PW'(dya_reg) * PW'(tmin_s);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            hitb_reg <= hita_reg;
            nxb_reg  <= nxa_reg;
            nyb_reg  <= nya_reg;
            fxb_reg  <= fxa_reg;
            fyb_reg  <= fya_reg;
        end
    end

    // ---------------- stage C: floor shift, add, output register ----------------
    logic signed [PW-1:0] shx, shy;
    logic signed [CW-1:0] hx_next, hy_next;
    logic                 m_tvalid_reg;
    logic [sbsi_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    assign shx     = px_reg >>> FRAC_BITS;    // arithmetic shift floors
    assign shy     = py_reg >>> FRAC_BITS;
    assign hx_next = fxb_reg + shx[CW-1:0];
    assign hy_next = fyb_reg + shy[CW-1:0];

    always_comb begin
        m_tdata_next = '0;
        if (hitb_reg) begin
            m_tdata_next[0]     = 1'b1;
            m_tdata_next[31:1]  = hx_next;
            m_tdata_next[62:32] = hy_next;
            m_tdata_next[64:63] = nxb_reg;
            m_tdata_next[66:65] = nyb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vb_reg;
        end
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- checks ----------------
    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata == '0)
        else $error("miss beat with nonzero payload");

    // at most one face normal is set
    a_one_face: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64:63] == 2'b00 || m_tdata[66:65] == 2'b00))
        else $error("both normals set");

    // normal code is never the unused value
    a_nrm_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64:63] != 2'b10 && m_tdata[66:65] != 2'b10))
        else $error("bad normal code");

    // on a hit, the entry parameter never exceeds one
    a_tmin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg && hita_reg |-> tmin_reg <= T_ONE)
        else $error("entry t above one on a hit");

    // a stalled output holds its beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

endmodule

[design/sbsi_div.sv]
// ----------------------------------------------------------------------------
// sbsi_div - pipelined restoring divider
// q = floor(num * 2^FRAC_BITS / den) for num <= den, one quotient bit per
// stage, FRAC_BITS+1 stages. Advances only when en is high.
// ----------------------------------------------------------------------------
module sbsi_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [sbsi_pkg::DW-1:0]       num,
    input  logic [sbsi_pkg::DW-1:0]       den,
    output logic [FRAC_BITS:0]            q
);
    localparam int NST = FRAC_BITS + 1;
    localparam int DW  = sbsi_pkg::DW;

    logic [DW:0]        rem_reg [NST];
    logic [DW:0]        rem_next[NST];
    logic [DW-1:0]      den_reg [NST];
    logic [DW-1:0]      src_den [NST];
    logic [DW:0]        src_rem [NST];
    logic [FRAC_BITS:0] src_q   [NST];
    logic [FRAC_BITS:0] q_reg   [NST];
    logic [FRAC_BITS:0] q_next  [NST];
    logic               ge      [NST];

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            if (k == 0) begin
                src_rem[k] = {1'b0, num};
                src_den[k] = den;
                src_q[k]   = '0;
            end else begin
                src_rem[k] = {rem_reg[k-1][DW-1:0], 1'b0};
                src_den[k] = den_reg[k-1];
                src_q[k]   = q_reg[k-1];
            end
            ge[k]       = src_rem[k] >= {1'b0, src_den[k]};
            rem_next[k] = ge[k] ? (src_rem[k] - {1'b0, src_den[k]}) : src_rem[k];
            q_next[k]   = {src_q[k][FRAC_BITS-1:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= src_den[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign q = q_reg[NST-1];

endmodule

[tb/segment_box_slab_intersect_unit_test.sv]
// ----------------------------------------------------------------------------
// segment_box_slab_intersect_unit_test - self-checking bench
// Drives segment/box beats through the slab intersection unit under random
// and long receiver stalls, predicts every result in fixed point and checks
// each output beat field by field in order.
// ----------------------------------------------------------------------------
module segment_box_slab_intersect_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int LATENCY    = FRAC + 5;
    localparam int N_RANDOM   = 1300;
    localparam int MAX_CYCLES = 400000;
    localparam longint T_UNIT = 64'sd1 << FRAC;
    localparam longint CMAX   = 64'sd1073741823;
    localparam longint CMIN   = -64'sd1073741824;

    typedef struct {
        longint from_x, from_y, to_x, to_y, rect_x, rect_y, rect_w, rect_h;
    } seg_box_t;

    typedef struct packed {
        logic                                hit;
        logic signed [sbsi_pkg::COORD_W-1:0] hit_x;
        logic signed [sbsi_pkg::COORD_W-1:0] hit_y;
        logic signed [1:0]                   normal_x;
        logic signed [1:0]                   normal_y;
    } contact_t;

    logic                        aclk;
    logic                        aresetn;
    logic [sbsi_pkg::IN_W-1:0]   s_tdata;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [sbsi_pkg::OUT_W-1:0]  m_tdata;
    logic                        m_tvalid;
    logic                        m_tready;

    segment_box_slab_intersect_unit #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    contact_t  expected_contacts[$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_off;
    longint    cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // floor(num * 2^FRAC / den), both nonnegative
    function automatic longint crossing_t(longint num, longint den);
        return (num <<< FRAC) / den;
    endfunction

    function automatic longint floor_frac(longint v);
        return v >>> FRAC;   // arithmetic shift floors for either sign
    endfunction

    // slab method over t in [0, 1]; x axis first, ties keep the earlier axis
    function automatic contact_t slab_intersect(seg_box_t b);
        contact_t r;
        longint f[2], e[2], lo[2], hi[2];
        longint t_enter, t_exit, tn, tf;
        int     entry_axis;
        int     face;
        logic signed [1:0] nrm[2];
        r = '{1'b0, '0, '0, sbsi_pkg::NRM_ZERO, sbsi_pkg::NRM_ZERO};
        f[0] = b.from_x; f[1] = b.from_y; e[0] = b.to_x; e[1] = b.to_y;
        lo[0] = b.rect_x; lo[1] = b.rect_y;
        hi[0] = b.rect_x + b.rect_w; hi[1] = b.rect_y + b.rect_h;
        t_enter = 0; t_exit = T_UNIT; entry_axis = -1; face = 0;
        nrm[0] = sbsi_pkg::NRM_ZERO; nrm[1] = sbsi_pkg::NRM_ZERO;
        for (int a = 0; a < 2; a++) begin
            if (f[a] < e[a]) begin
                if (f[a] > hi[a] || e[a] < lo[a]) return r;
                tn = (f[a] < lo[a]) ? crossing_t(lo[a] - f[a], e[a] - f[a]) : 0;
                tf = (e[a] > hi[a]) ? crossing_t(hi[a] - f[a], e[a] - f[a]) : T_UNIT;
            end else begin
                if (e[a] > hi[a] || f[a] < lo[a]) return r;
                tn = (f[a] > hi[a]) ? crossing_t(f[a] - hi[a], f[a] - e[a]) : 0;
                tf = (e[a] < lo[a]) ? crossing_t(f[a] - lo[a], f[a] - e[a]) : T_UNIT;
            end
            if (tn > t_enter) begin
                t_enter = tn;
                entry_axis = a;
                face = (f[a] < e[a]) ? -1 : 1;
            end
            if (tf < t_exit) t_exit = tf;
            if (t_enter > t_exit) return r;
        end
        if (entry_axis >= 0)
            nrm[entry_axis] = (face < 0) ? sbsi_pkg::NRM_NEG : sbsi_pkg::NRM_POS;
        r.hit      = 1'b1;
        r.hit_x    = sbsi_pkg::COORD_W'(f[0] + floor_frac((e[0] - f[0]) * t_enter));
        r.hit_y    = sbsi_pkg::COORD_W'(f[1] + floor_frac((e[1] - f[1]) * t_enter));
        r.normal_x = nrm[0];
        r.normal_y = nrm[1];
        return r;
    endfunction

    function automatic logic [sbsi_pkg::IN_W-1:0] pack_beat(seg_box_t b);
        return {2'b00, sbsi_pkg::SIZE_W'(b.rect_h), sbsi_pkg::SIZE_W'(b.rect_w),
                sbsi_pkg::COORD_W'(b.rect_y), sbsi_pkg::COORD_W'(b.rect_x),
                sbsi_pkg::COORD_W'(b.to_y), sbsi_pkg::COORD_W'(b.to_x),
                sbsi_pkg::COORD_W'(b.from_y), sbsi_pkg::COORD_W'(b.from_x)};
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // coordinates biased toward a small window so boxes get hit often
    function automatic longint rand_coord();
        case ($urandom_range(0, 9))
            0:       return CMIN + $urandom_range(0, 4000);
            1:       return CMAX - $urandom_range(0, 4000);
            2:       return longint'($urandom_range(0, 32'h7fffffff)) + CMIN;
            default: return longint'($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    function automatic longint rand_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return CMAX - $urandom_range(0, 100);
            2:       return $urandom_range(0, 32'h3fffffff);
            default: return $urandom_range(0, 800000);
        endcase
    endfunction

    function automatic seg_box_t rand_item();
        seg_box_t b;
        b.rect_x = rand_coord(); b.rect_y = rand_coord();
        b.rect_w = rand_size();  b.rect_h = rand_size();
        b.from_x = rand_coord(); b.from_y = rand_coord();
        b.to_x   = rand_coord(); b.to_y   = rand_coord();
        case ($urandom_range(0, 5))
            0: begin                        // point-like segment
                b.to_x = b.from_x; b.to_y = b.from_y;
            end
            1: b.to_x = b.from_x;           // vertical
            2: b.to_y = b.from_y;           // horizontal
            default: ;
        endcase
        // keep the box inside the coordinate range most of the time
        if ($urandom_range(0, 7) != 0) begin
            if (b.rect_x + b.rect_w > CMAX) b.rect_w = CMAX - b.rect_x;
            if (b.rect_y + b.rect_h > CMAX) b.rect_h = CMAX - b.rect_y;
            if (b.rect_w < 0) b.rect_w = 0;
            if (b.rect_h < 0) b.rect_h = 0;
        end
        return b;
    endfunction

    // tvalid drops only when the sender idles, so back-to-back beats
    // see a single update per edge
    task automatic send_item(seg_box_t b);
        bit idle;
        idle = send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct;
        if (idle) s_tvalid <= 1'b0;
        while (idle) begin
            @(posedge aclk);
            idle = $urandom_range(0, 99) < send_idle_pct;
        end
        s_tdata  <= pack_beat(b);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_contacts.push_back(slab_intersect(b));
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // output checker
    always @(posedge aclk) begin
        contact_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit      = m_tdata[0];
            got.hit_x    = m_tdata[31:1];
            got.hit_y    = m_tdata[62:32];
            got.normal_x = m_tdata[64:63];
            got.normal_y = m_tdata[66:65];
            if (expected_contacts.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = expected_contacts.pop_front();
                if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
                if (got.hit_x !== want.hit_x) report_mismatch("hit_x", got.hit_x, want.hit_x);
                if (got.hit_y !== want.hit_y) report_mismatch("hit_y", got.hit_y, want.hit_y);
                if (got.normal_x !== want.normal_x)
                    report_mismatch("normal_x", got.normal_x, want.normal_x);
                if (got.normal_y !== want.normal_y)
                    report_mismatch("normal_y", got.normal_y, want.normal_y);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("FAIL segment_box_slab_intersect_unit");
            $finish;
        end
    end

    // hold-off process: long receiver stall while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        wait (cycles > 3000);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // directed table: segment, box, and a typed expectation where obvious
    typedef struct {
        seg_box_t item;
        bit       typed;
        contact_t want;
    } directed_row_t;

    directed_row_t directed[$];

    task automatic add_row(longint fx, longint fy, longint tx, longint ty,
                           longint rx, longint ry, longint rw, longint rh,
                           bit typed, logic hit = 0, longint hx = 0, longint hy = 0,
                           logic signed [1:0] nx = sbsi_pkg::NRM_ZERO,
                           logic signed [1:0] ny = sbsi_pkg::NRM_ZERO);
        directed_row_t row;
        row.item  = '{fx, fy, tx, ty, rx, ry, rw, rh};
        row.typed = typed;
        row.want  = '{hit, sbsi_pkg::COORD_W'(hx), sbsi_pkg::COORD_W'(hy), nx, ny};
        directed.push_back(row);
    endtask

    localparam longint ONE = 64'sd65536;

    initial begin
        contact_t pred;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        mismatches = 0;
        send_idle_pct = 37;
        recv_idle_pct = 84;

        // miss, everything zero
        add_row(0, 0, ONE, 0, 5*ONE, 5*ONE, ONE, ONE, 1);
        // start inside: entry is the start, no normal
        add_row(ONE, ONE, 3*ONE, 3*ONE, 0, 0, 2*ONE, 2*ONE, 1, 1, ONE, ONE);
        // rising x enters left face: normal x -1
        add_row(0, ONE, 4*ONE, ONE, 2*ONE, 0, 4*ONE, 4*ONE, 1, 1, 2*ONE, ONE,
                sbsi_pkg::NRM_NEG);
        // falling x enters right face: normal x +1
        add_row(8*ONE, ONE, 0, ONE, 0, 0, 4*ONE, 4*ONE, 1, 1, 4*ONE, ONE,
                sbsi_pkg::NRM_POS);
        // rising y enters bottom face
        add_row(ONE, 0, ONE, 4*ONE, 0, 2*ONE, 4*ONE, 4*ONE, 1, 1, ONE, 2*ONE,
                sbsi_pkg::NRM_ZERO, sbsi_pkg::NRM_NEG);
        // falling y enters top face
        add_row(ONE, 8*ONE, ONE, 0, 0, 0, 4*ONE, 4*ONE, 1, 1, ONE, 4*ONE,
                sbsi_pkg::NRM_ZERO, sbsi_pkg::NRM_POS);
        // corner tie: x keeps the normal
        add_row(0, 0, 4*ONE, 4*ONE, 2*ONE, 2*ONE, ONE, ONE, 1, 1, 2*ONE, 2*ONE,
                sbsi_pkg::NRM_NEG);
        // degenerate point inside, on boundary, outside
        add_row(ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE, 1, 1, ONE, ONE);
        add_row(2*ONE, 0, 2*ONE, 0, 0, 0, 2*ONE, 2*ONE, 1, 1, 2*ONE, 0);
        add_row(3*ONE, 0, 3*ONE, 0, 0, 0, 2*ONE, 2*ONE, 1);
        // zero-size box touched and missed
        add_row(0, 0, 4*ONE, 0, ONE, 0, 0, 0, 1, 1, ONE, 0, sbsi_pkg::NRM_NEG);
        add_row(0, ONE, 4*ONE, ONE, ONE, 0, 0, 0, 1);
        // extremes of every field
        add_row(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 0);
        add_row(CMAX, CMAX, CMIN, CMIN, 0, 0, CMAX, CMAX, 0);
        add_row(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, 0);
        add_row(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, 0, CMAX, 0);
        add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 1, CMAX, CMAX);
        add_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 1, 1, CMIN, CMIN);
        // fractional entry with negative direction
        add_row(7*ONE + 3, -5*ONE + 1, -9*ONE, 2*ONE + 7, -ONE, -ONE, ONE + 5, 3*ONE, 0);
        add_row(-3, 5, 11*ONE + 1, -7*ONE - 9, ONE + 1, -2*ONE, ONE, ONE, 0);
        // exits before entry: slab intervals disjoint
        add_row(0, 0, 4*ONE, 4*ONE, 3*ONE, 0, ONE, ONE, 1);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].typed) begin
                pred = slab_intersect(directed[i].item);
                if (pred != directed[i].want)
                    report_mismatch($sformatf("directed row %0d predictor", i),
                                    pred.hit, directed[i].want.hit);
            end
            send_item(directed[i].item);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 37;
            end else if (i == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(rand_item());
        end
        s_tvalid <= 1'b0;

        while (expected_contacts.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        if (mismatches == 0) begin
            $display("PASS segment_box_slab_intersect_unit");
        end else begin
            $display("FAIL segment_box_slab_intersect_unit");
        end
        $finish;
    end

endmodule

[sim.f]
design/sbsi_pkg.sv
design/sbsi_div.sv
design/segment_box_slab_intersect_unit.sv
tb/segment_box_slab_intersect_unit_test.sv
